// ===== rtl/core/aeth_pkg.sv =====
// ----------------------------------------------------------------------------
// aeth_pkg
// Shared types and constants of the audio envelope tier hysteresis block.
// ----------------------------------------------------------------------------
package aeth_pkg;

   localparam int SAMPLE_W   = 8;
   localparam int COEFF_W    = 8;
   localparam int LEVEL_W    = 9;
   localparam int ENV_W      = 17;
   localparam int PROD_W     = ENV_W + COEFF_W;
   localparam int TIER_W     = 2;
   localparam int SCALE_W    = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 9;

   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [COEFF_W-1:0] ATTACK_RST      = 8'd80;
   localparam logic [COEFF_W-1:0] RELEASE_RST     = 8'd240;
   localparam logic [LEVEL_W-1:0] LOW_TO_MID_RST  = 9'd25;
   localparam logic [LEVEL_W-1:0] MID_TO_LOW_RST  = 9'd15;
   localparam logic [LEVEL_W-1:0] MID_TO_HIGH_RST = 9'd65;
   localparam logic [LEVEL_W-1:0] HIGH_TO_MID_RST = 9'd45;

   // peak magnitude that maps to the full level
   localparam logic [SAMPLE_W-1:0] PEAK_MAX   = 8'd128;
   localparam logic [LEVEL_W-1:0]  LEVEL_CLIP = 9'd255;

   localparam logic [SCALE_W-1:0] SCALE_LOW_Q8  = 16'd30720;
   localparam logic [SCALE_W-1:0] SCALE_MID_Q8  = 16'd51200;
   localparam logic [SCALE_W-1:0] SCALE_HIGH_Q8 = 16'd65280;

   localparam logic [TIER_W-1:0] TIER_LOW  = 2'd0;
   localparam logic [TIER_W-1:0] TIER_MID  = 2'd1;
   localparam logic [TIER_W-1:0] TIER_HIGH = 2'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ATTACK      = 3'd0,
      CSR_RELEASE     = 3'd1,
      CSR_LOW_TO_MID  = 3'd2,
      CSR_MID_TO_LOW  = 3'd3,
      CSR_MID_TO_HIGH = 3'd4,
      CSR_HIGH_TO_MID = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL1,
      BK_ADD1,
      BK_MUL2,
      BK_ADD2,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      logic [COEFF_W-1:0] attack_coeff;
      logic [COEFF_W-1:0] release_coeff;
      logic [LEVEL_W-1:0] low_to_mid_above;
      logic [LEVEL_W-1:0] mid_to_low_below;
      logic [LEVEL_W-1:0] mid_to_high_above;
      logic [LEVEL_W-1:0] high_to_mid_below;
   } cfg_type;

   // one frame-end job handed from front to back
   typedef struct packed {
      logic [SAMPLE_W-1:0] peak;
      logic                capture;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic               busy;
      logic [SCALE_W-1:0] scale;
   } back_status_type;

endpackage

// ===== rtl/core/aeth_ifs.sv =====
// ----------------------------------------------------------------------------
// aeth channel interfaces
// Request, response and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface aeth_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [aeth_pkg::SAMPLE_W-1:0] sample;
   logic                              channel_active;
   logic                              capture_ok;
   logic                              playing;
   logic                              last_in_frame;

   modport source (output valid, sample, channel_active, capture_ok, playing,
                   last_in_frame, input ready);
   modport sink   (input valid, sample, channel_active, capture_ok, playing,
                   last_in_frame, output ready);
endinterface

interface aeth_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [aeth_pkg::LEVEL_W-1:0]      render_level;
   logic [aeth_pkg::LEVEL_W-1:0]      tier_level;
   logic [aeth_pkg::TIER_W-1:0]       tier;
   logic [7:0]                        brightness_scale;

   modport source (output valid, render_level, tier_level, tier, brightness_scale,
                   input ready);
   modport sink   (input valid, render_level, tier_level, tier, brightness_scale,
                   output ready);
endinterface

interface aeth_csr_if;
   logic                              valid;
   logic                              ready;
   logic [aeth_pkg::CSR_INDEX_W-1:0]  index;
   logic [aeth_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/aeth_front.sv =====
// ----------------------------------------------------------------------------
// aeth_front
// Accepts sample words, tracks the frame peak and queues one job per frame end while playing.
// ----------------------------------------------------------------------------
module aeth_front
   import aeth_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   aeth_req_if.sink          req_chan,
   input  queue_status_type  q_status,
   output logic              push,
   output job_type           push_job
);

   logic [SAMPLE_W-1:0] peak_ff;
   logic [SAMPLE_W-1:0] peak_in;
   logic [SAMPLE_W-1:0] mag;
   logic [SAMPLE_W-1:0] peak_upd;
   logic                accept;

   assign req_chan.ready = !q_status.full;
   assign accept         = req_chan.valid && req_chan.ready;

   // two's complement magnitude, -128 gives 128
   assign mag = req_chan.sample[SAMPLE_W-1] ? (~req_chan.sample + 1'b1)
                                             : req_chan.sample;

   always_comb begin
      peak_upd = peak_ff;
      if (req_chan.channel_active && (mag > peak_ff)) begin
         peak_upd = mag;
      end
   end

   always_comb begin
      peak_in = peak_ff;
      push    = 1'b0;
      if (accept) begin
         if (!req_chan.playing) begin
            if (req_chan.last_in_frame) begin
               peak_in = '0;
            end
         end else if (req_chan.last_in_frame) begin
            push    = 1'b1;
            peak_in = '0;
         end else begin
            peak_in = peak_upd;
         end
      end
   end

   assign push_job.peak    = peak_upd;
   assign push_job.capture = req_chan.capture_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= '0;
      end else begin
         peak_ff <= peak_in;
      end
   end

endmodule

// ===== rtl/core/aeth_queue.sv =====
// ----------------------------------------------------------------------------
// aeth_queue
// Small job queue between the front and back ends.
// ----------------------------------------------------------------------------
module aeth_queue
   import aeth_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  job_type           push_job,
   input  logic              pop,
   output job_type           pop_job,
   output queue_status_type  status
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   job_type         entry_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [PtrW-1:0] rd_ptr_in;
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;
   logic            do_push;
   logic            do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CntW'(DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_job      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/core/aeth_back.sv =====
// ----------------------------------------------------------------------------
// aeth_back
// Runs the two envelope steps on one shared multiplier, then the tier
// classifier and scale smoothing, and holds the response word.
// ----------------------------------------------------------------------------
module aeth_back
   import aeth_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             job_valid,
   input  job_type          job,
   output logic             job_pop,
   aeth_rsp_if.source       rsp_chan,
   output back_status_type  status
);

   back_state_type      state_ff;
   back_state_type      state_in;
   job_type             job_ff;
   logic [ENV_W-1:0]    env_ff;
   logic [ENV_W-1:0]    env_in;
   logic [PROD_W-1:0]   prod_ff;
   logic [LEVEL_W-1:0]  render_ff;
   logic [TIER_W-1:0]   tier_ff;
   logic [TIER_W-1:0]   tier_in;
   logic [SCALE_W-1:0]  scale_ff;
   logic [SCALE_W-1:0]  scale_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [LEVEL_W-1:0]  rsp_render_ff;
   logic [LEVEL_W-1:0]  rsp_tier_level_ff;
   logic [TIER_W-1:0]   rsp_tier_ff;
   logic [7:0]          rsp_scale_ff;

   logic                out_free;
   logic                load_job;
   logic                load_prod;
   logic                load_env;
   logic                load_render;
   logic                finish;

   logic [LEVEL_W-1:0]  level;
   logic [ENV_W-1:0]    target;
   logic                rising;
   logic [ENV_W-1:0]    diff;
   logic [ENV_W-1:0]    mul_a;
   logic [COEFF_W-1:0]  mul_b;
   logic [PROD_W-1:0]   product;
   logic [ENV_W-1:0]    step;
   logic [ENV_W-1:0]    env_step;
   logic [LEVEL_W-1:0]  tier_level;
   logic [SCALE_W-1:0]  scale_target;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: if (job_valid) state_in = BK_MUL1;
         BK_MUL1: state_in = BK_ADD1;
         BK_ADD1: state_in = BK_MUL2;
         BK_MUL2: state_in = BK_ADD2;
         BK_ADD2: state_in = BK_DONE;
         BK_DONE: if (out_free) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      load_job    = 1'b0;
      load_prod   = 1'b0;
      load_env    = 1'b0;
      load_render = 1'b0;
      finish      = 1'b0;
      case (state_ff)
         BK_IDLE: load_job = job_valid;
         BK_MUL1, BK_MUL2: load_prod = 1'b1;
         BK_ADD1: begin
            load_env    = 1'b1;
            load_render = 1'b1;
         end
         BK_ADD2: load_env = 1'b1;
         BK_DONE: finish = out_free;
         default: load_job = 1'b0;
      endcase
   end

   assign job_pop = load_job;

   // envelope datapath
   assign level   = (job_ff.peak > PEAK_MAX) ? LEVEL_CLIP : {job_ff.peak, 1'b0};
   assign target  = {level, 8'b0};
   assign rising  = target > env_ff;
   assign diff    = rising ? (target - env_ff) : (env_ff - target);
   assign mul_a   = job_ff.capture ? diff : env_ff;
   assign mul_b   = (job_ff.capture && rising) ? cfg.attack_coeff : cfg.release_coeff;
   assign product = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign step    = prod_ff[PROD_W-1:8];

   always_comb begin
      if (!job_ff.capture) begin
         env_step = step;
      end else if (rising) begin
         env_step = env_ff + step;
      end else begin
         env_step = env_ff - step;
      end
   end

   assign env_in = load_env ? env_step : env_ff;

   // tier hysteresis on the level after the second step
   assign tier_level = env_ff[ENV_W-1:8];

   always_comb begin
      tier_in = tier_ff;
      case (tier_ff)
         TIER_LOW: begin
            if (tier_level > cfg.low_to_mid_above) tier_in = TIER_MID;
         end
         TIER_MID: begin
            // above-test wins when the mid thresholds overlap
            if (tier_level > cfg.mid_to_high_above) begin
               tier_in = TIER_HIGH;
            end else if (tier_level < cfg.mid_to_low_below) begin
               tier_in = TIER_LOW;
            end
         end
         default: begin
            if (tier_level < cfg.high_to_mid_below) tier_in = TIER_MID;
         end
      endcase
   end

   always_comb begin
      case (tier_in)
         TIER_LOW: scale_target = SCALE_LOW_Q8;
         TIER_MID: scale_target = SCALE_MID_Q8;
         default:  scale_target = SCALE_HIGH_Q8;
      endcase
      if (scale_target > scale_ff) begin
         scale_in = scale_ff + ((scale_target - scale_ff) >> 2);
      end else begin
         scale_in = scale_ff - ((scale_ff - scale_target) >> 3);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         env_ff       <= '0;
         tier_ff      <= TIER_LOW;
         scale_ff     <= SCALE_LOW_Q8;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         env_ff       <= env_in;
         rsp_valid_ff <= rsp_valid_in;
         if (finish) begin
            tier_ff  <= tier_in;
            scale_ff <= scale_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_job) begin
         job_ff <= job;
      end
      if (load_prod) begin
         prod_ff <= product;
      end
      if (load_render) begin
         render_ff <= env_step[ENV_W-1:8];
      end
      if (finish) begin
         rsp_render_ff     <= render_ff;
         rsp_tier_level_ff <= tier_level;
         rsp_tier_ff       <= tier_in;
         rsp_scale_ff      <= scale_in[SCALE_W-1:8];
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.render_level     = rsp_render_ff;
   assign rsp_chan.tier_level       = rsp_tier_level_ff;
   assign rsp_chan.tier             = rsp_tier_ff;
   assign rsp_chan.brightness_scale = rsp_scale_ff;

   assign status.busy  = (state_ff != BK_IDLE);
   assign status.scale = scale_ff;

endmodule

// ===== rtl/core/audio_envelope_tier_hysteresis.sv =====
// ----------------------------------------------------------------------------
// audio_envelope_tier_hysteresis
// Frame-peak envelope follower with attack/release steps, three-tier
// hysteresis classifier and smoothed brightness scale.
//
//   channel    dir  handshake      payload
//   req_chan   in   valid/ready    sample, channel_active, capture_ok,
//                                  playing, last_in_frame
//   rsp_chan   out  valid/ready    render_level, tier_level, tier,
//                                  brightness_scale
//   csr_chan   in   valid/ready    index, data (ready always high)
//
// A sample word that does not end a frame at most updates the frame peak.
// A frame-end word while playing is queued; the back end takes it through
// job pickup, two multiply/add envelope steps on one 17x8 multiplier,
// classify and smooth, and then registers its response.
// Synchronous reset; no clearing pass, the block takes words right after.
// req_chan stalls only when the job queue is full; a stalled response
// holds the back end in its final step while the front keeps going.
// ----------------------------------------------------------------------------
module audio_envelope_tier_hysteresis
   import aeth_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   aeth_req_if.sink    req_chan,
   aeth_rsp_if.source  rsp_chan,
   aeth_csr_if.sink    csr_chan
);

   cfg_type           cfg_ff;
   logic              push;
   job_type           push_job;
   logic              pop;
   job_type           pop_job;
   queue_status_type  q_status;
   back_status_type   b_status;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_coeff      <= ATTACK_RST;
         cfg_ff.release_coeff     <= RELEASE_RST;
         cfg_ff.low_to_mid_above  <= LOW_TO_MID_RST;
         cfg_ff.mid_to_low_below  <= MID_TO_LOW_RST;
         cfg_ff.mid_to_high_above <= MID_TO_HIGH_RST;
         cfg_ff.high_to_mid_below <= HIGH_TO_MID_RST;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_index_type'(csr_chan.index))
            CSR_ATTACK:      cfg_ff.attack_coeff      <= csr_chan.data[COEFF_W-1:0];
            CSR_RELEASE:     cfg_ff.release_coeff     <= csr_chan.data[COEFF_W-1:0];
            CSR_LOW_TO_MID:  cfg_ff.low_to_mid_above  <= csr_chan.data;
            CSR_MID_TO_LOW:  cfg_ff.mid_to_low_below  <= csr_chan.data;
            CSR_MID_TO_HIGH: cfg_ff.mid_to_high_above <= csr_chan.data;
            CSR_HIGH_TO_MID: cfg_ff.high_to_mid_below <= csr_chan.data;
            default:         cfg_ff <= cfg_ff;
         endcase
      end
   end

   aeth_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_status (q_status),
      .push     (push),
      .push_job (push_job)
   );

   aeth_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .status   (q_status)
   );

   aeth_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (!q_status.empty),
      .job       (pop_job),
      .job_pop   (pop),
      .rsp_chan  (rsp_chan),
      .status    (b_status)
   );

`ifndef SYNTHESIS
   // a frame end while playing always leaves work queued or running
   a_frame_end_queued: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.playing && req_chan.last_in_frame)
      |=> (!q_status.empty || b_status.busy))
      else $error("frame-end word lost between front and back");

   a_scale_range: assert property (@(posedge clock) disable iff (reset)
      (b_status.scale >= SCALE_LOW_Q8) && (b_status.scale <= SCALE_HIGH_Q8))
      else $error("smoothed scale left its target range");

   a_tier_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.tier_level <= 9'd256) && (rsp_chan.render_level <= 9'd256))
      else $error("envelope level above full scale");

   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      !(q_status.empty && q_status.full))
      else $error("job queue both empty and full");
`endif

endmodule

// ===== tb/envelope_scoreboard_pkg.sv =====
// ----------------------------------------------------------------------------
// envelope_scoreboard_pkg
// Frame-result predictor and in-order checker for the envelope follower:
// tracks peak, Q8 envelope, hysteresis tier and smoothed scale per word.
// ----------------------------------------------------------------------------
package envelope_scoreboard_pkg;
   import aeth_pkg::*;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       channel_active;
      logic                       capture_ok;
      logic                       playing;
      logic                       last_in_frame;
   } channel_word_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] render_level;
      logic [LEVEL_W-1:0] tier_level;
      logic [TIER_W-1:0]  tier;
      logic [7:0]         brightness_scale;
   } frame_result_type;

   localparam int REPORT_LIMIT = 10;

   class envelope_scoreboard;
      cfg_type            cfg;
      logic [8:0]         peak;
      logic [ENV_W-1:0]   envelope;
      logic [TIER_W-1:0]  tier;
      logic [SCALE_W-1:0] scale;
      frame_result_type   expected_q[$];
      int                 mismatches;
      int                 frames;
      int                 decay_frames;
      int                 tier_hits[3];

      function new();
         cfg.attack_coeff      = ATTACK_RST;
         cfg.release_coeff     = RELEASE_RST;
         cfg.low_to_mid_above  = LOW_TO_MID_RST;
         cfg.mid_to_low_below  = MID_TO_LOW_RST;
         cfg.mid_to_high_above = MID_TO_HIGH_RST;
         cfg.high_to_mid_below = HIGH_TO_MID_RST;
         peak         = '0;
         envelope     = '0;
         tier         = TIER_LOW;
         scale        = SCALE_LOW_Q8;
         mismatches   = 0;
         frames       = 0;
         decay_frames = 0;
         tier_hits    = '{0, 0, 0};
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (csr_index_type'(idx))
            CSR_ATTACK:      cfg.attack_coeff      = data[COEFF_W-1:0];
            CSR_RELEASE:     cfg.release_coeff     = data[COEFF_W-1:0];
            CSR_LOW_TO_MID:  cfg.low_to_mid_above  = data;
            CSR_MID_TO_LOW:  cfg.mid_to_low_below  = data;
            CSR_MID_TO_HIGH: cfg.mid_to_high_above = data;
            CSR_HIGH_TO_MID: cfg.high_to_mid_below = data;
            default: ;
         endcase
      endfunction

      function void step_envelope(logic capture);
         logic [PROD_W-1:0]  prod;
         logic [ENV_W-1:0]   target;
         logic [LEVEL_W-1:0] level;
         if (!capture) begin
            // no capture data: plain decay by the release factor
            prod     = PROD_W'(envelope) * PROD_W'(cfg.release_coeff);
            envelope = prod[PROD_W-1:8];
         end else begin
            level  = (peak > 9'(PEAK_MAX)) ? LEVEL_CLIP : {peak[7:0], 1'b0};
            target = {level, 8'h00};
            if (target > envelope) begin
               prod     = PROD_W'(target - envelope) * PROD_W'(cfg.attack_coeff);
               envelope = envelope + prod[PROD_W-1:8];
            end else begin
               prod     = PROD_W'(envelope - target) * PROD_W'(cfg.release_coeff);
               envelope = envelope - prod[PROD_W-1:8];
            end
         end
      endfunction

      function void classify(logic [LEVEL_W-1:0] level);
         case (tier)
            TIER_LOW: begin
               if (level > cfg.low_to_mid_above) tier = TIER_MID;
            end
            TIER_MID: begin
               // both tests on the same level, the upward one wins
               if (level < cfg.mid_to_low_below) tier = TIER_LOW;
               if (level > cfg.mid_to_high_above) tier = TIER_HIGH;
            end
            default: begin
               if (level < cfg.high_to_mid_below) tier = TIER_MID;
            end
         endcase
      endfunction

      function void smooth_scale();
         logic [SCALE_W-1:0] goal;
         case (tier)
            TIER_LOW: goal = SCALE_LOW_Q8;
            TIER_MID: goal = SCALE_MID_Q8;
            default:  goal = SCALE_HIGH_Q8;
         endcase
         if (goal > scale) scale = scale + ((goal - scale) >> 2);
         else scale = scale - ((scale - goal) >> 3);
      endfunction

      function void note_word(channel_word_type w);
         logic [8:0]       mag;
         frame_result_type r;
         if (!w.playing) begin
            if (w.last_in_frame) peak = '0;
         end else begin
            if (w.channel_active) begin
               mag = w.sample[7] ? 9'd256 - {1'b0, w.sample} : {1'b0, w.sample};
               if (mag > peak) peak = mag;
            end
            if (w.last_in_frame) begin
               step_envelope(w.capture_ok);
               r.render_level = envelope[ENV_W-1:8];
               step_envelope(w.capture_ok);
               r.tier_level = envelope[ENV_W-1:8];
               classify(r.tier_level);
               smooth_scale();
               peak               = '0;
               r.tier             = tier;
               r.brightness_scale = scale[SCALE_W-1:8];
               expected_q.push_back(r);
               frames++;
               if (!w.capture_ok) decay_frames++;
               tier_hits[tier]++;
            end
         end
      endfunction

      function void note_mismatch(string what);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) $display("%0t ns: %s", $time, what);
      endfunction

      function void check_result(frame_result_type got);
         frame_result_type want;
         if (expected_q.size() == 0) begin
            note_mismatch($sformatf("result word with nothing expected: %p", got));
         end else begin
            want = expected_q.pop_front();
            if (got.render_level !== want.render_level)
               note_mismatch($sformatf("render_level expected %0d actual %0d",
                                       want.render_level, got.render_level));
            if (got.tier_level !== want.tier_level)
               note_mismatch($sformatf("tier_level expected %0d actual %0d",
                                       want.tier_level, got.tier_level));
            if (got.tier !== want.tier)
               note_mismatch($sformatf("tier expected %0d actual %0d", want.tier, got.tier));
            if (got.brightness_scale !== want.brightness_scale)
               note_mismatch($sformatf("brightness_scale expected %0d actual %0d",
                                       want.brightness_scale, got.brightness_scale));
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

endpackage

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives channel sample words and register writes into the envelope tier block
// with random gaps on sample and response channels; checks each frame result.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import aeth_pkg::*;
   import envelope_scoreboard_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 3'd7;
   localparam int DRAIN_CYCLES = 12;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   no_idle = 1'b0;
   int   played_words = 0;
   int   settings_written = 0;

   envelope_scoreboard sb;

   aeth_req_if req_chan ();
   aeth_rsp_if rsp_chan ();
   aeth_csr_if csr_chan ();

   audio_envelope_tier_hysteresis dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #2 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] rand_sample(int amp);
      int v;
      v = $urandom_range(0, amp);
      if ($urandom_range(0, 1)) v = -v;
      if (v > 127) v = 127;
      return SAMPLE_W'(v);
   endfunction

   function automatic int pick_amp();
      int r;
      r = $urandom_range(0, 3);
      case (r)
         0:       return 8;
         1:       return 40;
         2:       return 90;
         default: return 128;
      endcase
   endfunction

   function automatic logic rand_bit();
      return logic'($urandom_range(0, 1));
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_data(int hi);
      return CSR_DATA_W'($urandom_range(0, hi));
   endfunction

   task automatic send_word(logic signed [SAMPLE_W-1:0] s, logic act, logic cap,
                            logic play, logic last);
      int               gap;
      channel_word_type w;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      w.sample         = s;
      w.channel_active = act;
      w.capture_ok     = cap;
      w.playing        = play;
      w.last_in_frame  = last;
      req_chan.valid          <= 1'b1;
      req_chan.sample         <= w.sample;
      req_chan.channel_active <= w.channel_active;
      req_chan.capture_ok     <= w.capture_ok;
      req_chan.playing        <= w.playing;
      req_chan.last_in_frame  <= w.last_in_frame;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_word(w);
      if (play) played_words++;
   endtask

   task automatic send_frame(int n, int amp, logic cap, int active_pct);
      for (int i = 0; i < n; i++) begin
         send_word(rand_sample(amp), $urandom_range(0, 99) < active_pct,
                   (i == n - 1) ? cap : rand_bit(), 1'b1, i == n - 1);
      end
   endtask

   task automatic put_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= data;
      do @(posedge clock); while (!csr_chan.ready);
      sb.set_reg(idx, data);
   endtask

   task automatic apply_settings(logic [CSR_DATA_W-1:0] atk, logic [CSR_DATA_W-1:0] rel,
                                 logic [CSR_DATA_W-1:0] lm, logic [CSR_DATA_W-1:0] ml,
                                 logic [CSR_DATA_W-1:0] mh, logic [CSR_DATA_W-1:0] hm);
      put_reg(CSR_ATTACK, atk);
      put_reg(CSR_RELEASE, rel);
      put_reg(CSR_LOW_TO_MID, lm);
      put_reg(CSR_MID_TO_LOW, ml);
      put_reg(CSR_MID_TO_HIGH, mh);
      put_reg(CSR_HIGH_TO_MID, hm);
      csr_chan.valid <= 1'b0;
      settings_written++;
   endtask

   // wait for all frame results, then let the back end go quiet
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_run(int count);
      int stop;
      int kind;
      int n;
      int cut;
      stop = played_words + count;
      while (played_words < stop) begin
         no_idle = ($urandom_range(0, 7) == 0);
         kind = $urandom_range(0, 99);
         if (kind < 72) begin
            send_frame($urandom_range(1, 6), pick_amp(), $urandom_range(0, 7) != 0, 85);
         end else if (kind < 82) begin
            // playback paused: words pass through, a frame end only clears the peak
            repeat ($urandom_range(1, 4))
               send_word(rand_sample(128), rand_bit(), rand_bit(), 1'b0, rand_bit());
         end else if (kind < 94) begin
            // frame interrupted by a pause, may end on either side of it
            n   = $urandom_range(2, 5);
            cut = $urandom_range(0, n - 1);
            for (int i = 0; i < n; i++)
               send_word(rand_sample(pick_amp()), 1'b1, rand_bit(), i != cut, i == n - 1);
         end else begin
            send_word(rand_sample(128), rand_bit(), rand_bit(), rand_bit(), rand_bit());
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin : rsp_side
      int               stall_left;
      frame_result_type got;
      stall_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.render_level     = rsp_chan.render_level;
            got.tier_level       = rsp_chan.tier_level;
            got.tier             = rsp_chan.tier;
            got.brightness_scale = rsp_chan.brightness_scale;
            sb.check_result(got);
         end
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   initial begin : stimulus
      sb = new();
      req_chan.valid          = 1'b0;
      req_chan.sample         = '0;
      req_chan.channel_active = 1'b0;
      req_chan.capture_ok     = 1'b0;
      req_chan.playing        = 1'b0;
      req_chan.last_in_frame  = 1'b0;
      csr_chan.valid          = 1'b0;
      csr_chan.index          = '0;
      csr_chan.data           = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      apply_settings(80, 240, 25, 15, 65, 45);

      // full-scale, extreme and small samples
      send_word(-128, 1'b1, 1'b1, 1'b1, 1'b1);
      send_word(127, 1'b1, 1'b1, 1'b1, 1'b0);
      send_word(0, 1'b1, 1'b1, 1'b1, 1'b1);
      send_word(-1, 1'b1, 1'b1, 1'b1, 1'b1);
      send_word(1, 1'b1, 1'b1, 1'b1, 1'b1);
      // inactive channel does not count
      send_word(-128, 1'b0, 1'b1, 1'b1, 1'b1);
      // sample while paused is not counted
      send_word(-128, 1'b1, 1'b1, 1'b0, 1'b0);
      send_word(5, 1'b1, 1'b1, 1'b1, 1'b1);
      // frame end while paused still clears the peak
      send_word(100, 1'b1, 1'b1, 1'b1, 1'b0);
      send_word(0, 1'b1, 1'b1, 1'b0, 1'b1);
      send_word(0, 1'b1, 1'b1, 1'b1, 1'b1);
      // capture missing: decay only
      send_word(-128, 1'b1, 1'b0, 1'b1, 1'b1);
      send_word(64, 1'b1, 1'b0, 1'b1, 1'b1);
      // climb through the tiers, then fall back
      repeat (5) send_word(-128, 1'b1, 1'b1, 1'b1, 1'b1);
      repeat (4) send_word(0, 1'b1, 1'b1, 1'b1, 1'b1);

      random_run(75);
      settle();
      apply_settings(255, 255, 0, 0, 0, 0);
      random_run(60);
      settle();
      apply_settings(0, 0, 256, 256, 256, 256);
      random_run(40);
      settle();
      // mid tier thresholds overlap
      apply_settings(200, 100, 20, 120, 60, 40);
      random_run(75);
      settle();
      apply_settings(1, 1, 511, 511, 511, 0);
      random_run(40);
      settle();
      put_reg(CSR_SPARE, rand_data(511));
      apply_settings(rand_data(511), rand_data(511), rand_data(300),
                     rand_data(300), rand_data(300), rand_data(300));
      random_run(80);
      settle();

      $display("run covered %0d playing words and %0d frame results (%0d decay-only)",
               played_words, sb.frames, sb.decay_frames);
      $display("tier results low/mid/high: %0d/%0d/%0d over %0d register settings",
               sb.tier_hits[0], sb.tier_hits[1], sb.tier_hits[2], settings_written);
      if (sb.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin : watchdog
      #2ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/aeth_pkg.sv
rtl/core/aeth_ifs.sv
rtl/core/aeth_front.sv
rtl/core/aeth_queue.sv
rtl/core/aeth_back.sv
rtl/core/audio_envelope_tier_hysteresis.sv
tb/envelope_scoreboard_pkg.sv
tb/testbench.sv
